// ===== src/ptds_pkg.sv =====
// Shared widths, operation codes and cell structures of the periodic task scheduler.
package ptds_pkg;

	localparam int NUM_SLOTS = 16;
	localparam int FUNC_W = 3;
	localparam int IDX_W = 4;
	localparam int TIME_W = 32;
	localparam int CNT_W = $clog2(NUM_SLOTS + 1);
	localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

	localparam logic [FUNC_W-1:0] FUNC_TICK = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_ADD = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_SET_ACTIVE = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_REMOVE = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_SET_PERIOD = 3'd4;

	typedef struct packed {
		logic we;
		logic [FUNC_W-1:0] func;
		logic [IDX_W-1:0] task_index;
		logic [CNT_W-1:0] used_count;
		logic [TIME_W-1:0] period;
		logic make_active;
		logic [TIME_W-1:0] now;
	} cell_cmd_t;

	typedef struct packed {
		logic due;
		logic hit;
	} cell_stat_t;

endpackage

// ===== src/ptds_req_if.sv =====
// Request channel carrying one scheduler command per transaction.
interface ptds_req_if
	import ptds_pkg::*;
;
	logic valid;
	logic ready;
	logic [FUNC_W-1:0] func;
	logic [IDX_W-1:0] task_index;
	logic [TIME_W-1:0] period;
	logic make_active;
	logic [TIME_W-1:0] now_ms;

	modport source (output valid, func, task_index, period, make_active, now_ms, input ready);
	modport sink (input valid, func, task_index, period, make_active, now_ms, output ready);
endinterface

// ===== src/ptds_rsp_if.sv =====
// Response channel carrying one scheduler result per transaction.
interface ptds_rsp_if
	import ptds_pkg::*;
;
	logic valid;
	logic ready;
	logic ok;
	logic [IDX_W-1:0] slot;
	logic due;
	logic last;

	modport source (output valid, ok, slot, due, last, input ready);
	modport sink (input valid, ok, slot, due, last, output ready);
endinterface

// ===== src/ptds_cell.sv =====
// One task slot of the scheduler chain, with its share of the scan token.
module ptds_cell
	import ptds_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic [CNT_W-1:0] cell_idx,
	input cell_cmd_t cmd,
	input logic shift_en,
	input logic tok_in,
	output logic tok_out,
	output cell_stat_t stat
);

	logic valid_q;
	logic active_q;
	logic tok_q;
	logic [TIME_W-1:0] period_q;
	logic [TIME_W-1:0] last_run_q;
	logic sel_idx;
	logic sel_add;
	logic elapsed_ok;
	logic hit;
	logic wr;

	assign sel_idx = (CMP_W'(cell_idx) == CMP_W'(cmd.task_index));
	assign sel_add = (cell_idx == cmd.used_count);
	assign elapsed_ok = ((cmd.now - last_run_q) >= period_q);

	always_comb begin
		case (cmd.func)
			FUNC_ADD: hit = sel_add && (cmd.period != '0);
			FUNC_SET_ACTIVE: hit = sel_idx && valid_q;
			FUNC_REMOVE: hit = sel_idx && valid_q && active_q;
			FUNC_SET_PERIOD: hit = sel_idx && valid_q && active_q;
			default: hit = 1'b0;
		endcase
	end

	assign wr = cmd.we && hit;
	assign stat.hit = hit;
	assign stat.due = tok_q && valid_q && active_q && elapsed_ok;
	assign tok_out = tok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			active_q <= 1'b0;
			tok_q <= 1'b0;
		end else begin
			if (shift_en) begin
				tok_q <= tok_in;
			end
			if (wr) begin
				case (cmd.func)
					FUNC_ADD: begin
						valid_q <= 1'b1;
						active_q <= 1'b0;
					end
					FUNC_SET_ACTIVE: active_q <= cmd.make_active;
					FUNC_REMOVE: begin
						valid_q <= 1'b0;
						active_q <= 1'b0;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr && (cmd.func == FUNC_ADD)) begin
			period_q <= cmd.period;
			last_run_q <= cmd.now;
		end else if (wr && (cmd.func == FUNC_SET_PERIOD)) begin
			period_q <= cmd.period;
		end else if (wr && (cmd.func == FUNC_SET_ACTIVE) && cmd.make_active) begin
			last_run_q <= cmd.now;
		end else if (shift_en && stat.due) begin
			last_run_q <= cmd.now;
		end
	end

endmodule

// ===== src/periodic_task_due_scheduler_unit.sv =====
// Top level of the periodic task scheduler: command decode, scan control and result register.
//
// Channel  Role    Payload
// req      sink    func, task_index, period, make_active, now_ms
// rsp      source  ok, slot, due, last
//
// A command other than a tick yields one result.
// A tick walks a token down the chain of NUM_SLOTS cells, one cell per cycle
// while the result register is free, then emits the terminator.
// A stalled result register holds the token in place until the result is taken.
// Reset clears every slot's valid and active flags and the slot count.
module periodic_task_due_scheduler_unit
	import ptds_pkg::*;
(
	input logic clk,
	input logic arst_n,
	ptds_req_if.sink req,
	ptds_rsp_if.source rsp
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_TERM = 2'd2;

	logic [1:0] state_q;
	logic [CNT_W-1:0] used_count_q;
	logic [TIME_W-1:0] now_q;
	logic rsp_valid_q;
	logic rsp_ok_q;
	logic [IDX_W-1:0] rsp_slot_q;
	logic rsp_due_q;
	logic rsp_last_q;

	logic out_free;
	logic accept;
	logic start;
	logic cmd_we;
	logic shift_en;
	logic any_hit;
	logic any_due;
	logic [IDX_W-1:0] due_slot;
	logic [NUM_SLOTS-1:0] tok;
	logic [NUM_SLOTS-1:0] tok_in;
	cell_cmd_t cmd;
	cell_stat_t stat [NUM_SLOTS];

	assign out_free = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE) && out_free;
	assign accept = req.valid && req.ready;
	assign start = accept && (req.func == FUNC_TICK);
	assign cmd_we = accept && (req.func != FUNC_TICK);
	assign shift_en = start || ((state_q == ST_SCAN) && out_free);

	always_comb begin
		cmd.we = cmd_we;
		cmd.func = (state_q == ST_IDLE) ? req.func : FUNC_TICK;
		cmd.task_index = req.task_index;
		cmd.used_count = used_count_q;
		cmd.period = req.period;
		cmd.make_active = req.make_active;
		cmd.now = (state_q == ST_IDLE) ? req.now_ms : now_q;
	end

	assign tok_in = {tok[NUM_SLOTS-2:0], start};

	for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
		ptds_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.cell_idx(CNT_W'(g)),
			.cmd(cmd),
			.shift_en(shift_en),
			.tok_in(tok_in[g]),
			.tok_out(tok[g]),
			.stat(stat[g])
		);
	end

	always_comb begin
		any_hit = 1'b0;
		any_due = 1'b0;
		due_slot = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			any_hit = any_hit | stat[i].hit;
			any_due = any_due | stat[i].due;
			due_slot = due_slot | (stat[i].due ? IDX_W'(i) : '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			used_count_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd_we && (req.func == FUNC_ADD) && any_hit) begin
				used_count_q <= used_count_q + CNT_W'(1);
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (out_free && tok[NUM_SLOTS-1]) begin
						state_q <= ST_TERM;
					end
				end
				ST_TERM: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (out_free) begin
				rsp_valid_q <= cmd_we || (state_q == ST_TERM) || ((state_q == ST_SCAN) && any_due);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			now_q <= req.now_ms;
		end
		if (out_free) begin
			if (cmd_we) begin
				rsp_ok_q <= any_hit;
				rsp_slot_q <= (req.func == FUNC_ADD && any_hit) ? IDX_W'(used_count_q) : '0;
				rsp_due_q <= 1'b0;
				rsp_last_q <= 1'b1;
			end else if (state_q == ST_TERM) begin
				rsp_ok_q <= 1'b1;
				rsp_slot_q <= '0;
				rsp_due_q <= 1'b0;
				rsp_last_q <= 1'b1;
			end else begin
				rsp_ok_q <= 1'b1;
				rsp_slot_q <= due_slot;
				rsp_due_q <= 1'b1;
				rsp_last_q <= 1'b0;
			end
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.ok = rsp_ok_q;
	assign rsp.slot = rsp_slot_q;
	assign rsp.due = rsp_due_q;
	assign rsp.last = rsp_last_q;

endmodule

// ===== src/ptds_checker.sv =====
// Port-level assertions for the periodic task scheduler, bound to its top level.
module ptds_checker
	import ptds_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic [FUNC_W-1:0] req_func,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic rsp_ok,
	input logic [IDX_W-1:0] rsp_slot,
	input logic rsp_due,
	input logic rsp_last
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("Response dropped while stalled.");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_ok) && $stable(rsp_slot) &&
			$stable(rsp_due) && $stable(rsp_last))
		else $error("Response payload changed while stalled.");

	a_cmd_result: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_func != FUNC_TICK) |=>
			rsp_valid && rsp_last && !rsp_due)
		else $error("Command transaction did not yield a single final result.");

	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_func == FUNC_TICK) |=> !req_ready)
		else $error("Request accepted during a tick scan.");

	a_due_shape: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_due == !rsp_last) || (!rsp_due && rsp_last))
		else $error("Due result marked as final.");

endmodule

bind periodic_task_due_scheduler_unit ptds_checker u_ptds_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.req_func(req.func),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_ok(rsp.ok),
	.rsp_slot(rsp.slot),
	.rsp_due(rsp.due),
	.rsp_last(rsp.last)
);

// ===== tb/periodic_task_due_scheduler_unit_test.sv =====
// Self-checking testbench for the periodic task scheduler.
`timescale 1ns / 1ps

module periodic_task_due_scheduler_unit_test
	import ptds_pkg::*;
;

	localparam logic [FUNC_W-1:0] FUNC_UNUSED_LO = 3'd5;
	localparam logic [FUNC_W-1:0] FUNC_UNUSED_HI = 3'd7;
	localparam int RANDOM_CMDS = 190;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [IDX_W-1:0] task_index;
		logic [TIME_W-1:0] period;
		logic make_active;
		logic [TIME_W-1:0] now_ms;
	} cmd_t;

	typedef struct packed {
		logic ok;
		logic [IDX_W-1:0] slot;
		logic due;
		logic last;
	} result_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [IDX_W-1:0] task_index;
		logic [TIME_W-1:0] period;
		logic make_active;
		logic [TIME_W-1:0] now_ms;
		logic [4:0] reps;
		logic typed;
		logic ok;
		logic [IDX_W-1:0] slot;
	} plan_row_t;

	// Rows with typed set give a single written-in result; the rest use the predictor.
	localparam plan_row_t PLAN [25] = '{
		'{FUNC_TICK, 4'd0, 32'd0, 1'b0, 32'd0, 5'd1, 1'b1, 1'b1, 4'd0},
		'{FUNC_SET_ACTIVE, 4'd0, 32'd0, 1'b1, 32'd0, 5'd1, 1'b1, 1'b0, 4'd0},
		'{FUNC_REMOVE, 4'd15, 32'd0, 1'b0, 32'd0, 5'd1, 1'b1, 1'b0, 4'd0},
		'{FUNC_SET_PERIOD, 4'd3, 32'd7, 1'b0, 32'd0, 5'd1, 1'b1, 1'b0, 4'd0},
		'{FUNC_ADD, 4'd0, 32'd0, 1'b0, 32'd0, 5'd1, 1'b1, 1'b0, 4'd0},
		'{FUNC_ADD, 4'd9, 32'hFFFF_FFFF, 1'b1, 32'd5, 5'd1, 1'b1, 1'b1, 4'd0},
		'{FUNC_ADD, 4'd0, 32'd1, 1'b0, 32'd100, 5'd1, 1'b1, 1'b1, 4'd1},
		'{FUNC_REMOVE, 4'd0, 32'd0, 1'b0, 32'd0, 5'd1, 1'b1, 1'b0, 4'd0},
		'{FUNC_SET_PERIOD, 4'd1, 32'd9, 1'b0, 32'd0, 5'd1, 1'b1, 1'b0, 4'd0},
		'{FUNC_SET_ACTIVE, 4'd0, 32'd0, 1'b1, 32'd5, 5'd1, 1'b1, 1'b1, 4'd0},
		'{FUNC_SET_ACTIVE, 4'd1, 32'd0, 1'b1, 32'd100, 5'd1, 1'b1, 1'b1, 4'd0},
		'{FUNC_TICK, 4'd0, 32'd0, 1'b0, 32'd100, 5'd1, 1'b0, 1'b0, 4'd0},
		'{FUNC_TICK, 4'd0, 32'd0, 1'b0, 32'd101, 5'd1, 1'b0, 1'b0, 4'd0},
		'{FUNC_TICK, 4'd0, 32'd0, 1'b0, 32'd4, 5'd1, 1'b0, 1'b0, 4'd0},
		'{FUNC_SET_PERIOD, 4'd1, 32'd0, 1'b0, 32'd0, 5'd1, 1'b1, 1'b1, 4'd0},
		'{FUNC_TICK, 4'd0, 32'd0, 1'b0, 32'd4, 5'd1, 1'b0, 1'b0, 4'd0},
		'{FUNC_UNUSED_LO, 4'd15, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 5'd1, 1'b1, 1'b0, 4'd0},
		'{FUNC_SET_ACTIVE, 4'd1, 32'd0, 1'b0, 32'd4, 5'd1, 1'b1, 1'b1, 4'd0},
		'{FUNC_REMOVE, 4'd1, 32'd0, 1'b0, 32'd0, 5'd1, 1'b1, 1'b0, 4'd0},
		'{FUNC_SET_ACTIVE, 4'd1, 32'd0, 1'b1, 32'hFFFF_FFFF, 5'd1, 1'b1, 1'b1, 4'd0},
		'{FUNC_REMOVE, 4'd1, 32'd0, 1'b0, 32'd0, 5'd1, 1'b1, 1'b1, 4'd0},
		'{FUNC_SET_ACTIVE, 4'd1, 32'd0, 1'b1, 32'd0, 5'd1, 1'b1, 1'b0, 4'd0},
		'{FUNC_ADD, 4'd0, 32'd3, 1'b0, 32'd50, 5'd14, 1'b0, 1'b0, 4'd0},
		'{FUNC_ADD, 4'd0, 32'd3, 1'b0, 32'd50, 5'd1, 1'b1, 1'b0, 4'd0},
		'{FUNC_TICK, 4'd0, 32'd0, 1'b0, 32'hFFFF_FFFF, 5'd1, 1'b0, 1'b0, 4'd0}
	};

	logic clk;
	logic arst_n;

	ptds_req_if req_ch ();
	ptds_rsp_if rsp_ch ();

	periodic_task_due_scheduler_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	result_t awaited[$];
	int errors = 0;
	bit calm = 1'b0;
	bit hold_trigger = 1'b0;
	logic [TIME_W-1:0] clock_ms = '0;

	int slots_used = 0;
	bit slot_live [NUM_SLOTS];
	bit slot_on [NUM_SLOTS];
	logic [TIME_W-1:0] slot_every [NUM_SLOTS];
	logic [TIME_W-1:0] slot_stamp [NUM_SLOTS];

	initial begin
		clk = 1'b0;
	end

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("periodic_task_due_scheduler_unit_test: errors");
		$finish;
	end

	function automatic void push_result(input logic ok, input logic [IDX_W-1:0] slot,
			input logic due, input logic last);
		result_t r;
		r.ok = ok;
		r.slot = slot;
		r.due = due;
		r.last = last;
		awaited.push_back(r);
	endfunction

	function automatic void forecast_results(input cmd_t c);
		logic ok;
		logic [IDX_W-1:0] slot;
		logic [TIME_W-1:0] elapsed;
		int i;
		ok = 1'b0;
		slot = '0;
		case (c.func)
			FUNC_TICK: begin
				for (i = 0; i < NUM_SLOTS; i++) begin
					if (i < slots_used && slot_live[i] && slot_on[i]) begin
						elapsed = c.now_ms - slot_stamp[i];
						if (elapsed >= slot_every[i]) begin
							slot_stamp[i] = c.now_ms;
							push_result(1'b1, i[IDX_W-1:0], 1'b1, 1'b0);
						end
					end
				end
				ok = 1'b1;
			end
			FUNC_ADD: begin
				if (slots_used < NUM_SLOTS && c.period != '0) begin
					slot_live[slots_used] = 1'b1;
					slot_on[slots_used] = 1'b0;
					slot_every[slots_used] = c.period;
					slot_stamp[slots_used] = c.now_ms;
					slot = slots_used[IDX_W-1:0];
					slots_used++;
					ok = 1'b1;
				end
			end
			FUNC_SET_ACTIVE: begin
				if (slot_live[c.task_index]) begin
					slot_on[c.task_index] = c.make_active;
					if (c.make_active)
						slot_stamp[c.task_index] = c.now_ms;
					ok = 1'b1;
				end
			end
			FUNC_REMOVE: begin
				if (slot_live[c.task_index] && slot_on[c.task_index]) begin
					slot_live[c.task_index] = 1'b0;
					slot_on[c.task_index] = 1'b0;
					ok = 1'b1;
				end
			end
			FUNC_SET_PERIOD: begin
				if (slot_live[c.task_index] && slot_on[c.task_index]) begin
					slot_every[c.task_index] = c.period;
					ok = 1'b1;
				end
			end
			default: ok = 1'b0;
		endcase
		push_result(ok, slot, 1'b0, 1'b1);
	endfunction

	function automatic cmd_t random_cmd();
		cmd_t c;
		int pick;
		pick = $urandom_range(0, 99);
		c.task_index = IDX_W'($urandom_range(0, NUM_SLOTS - 1));
		c.period = $urandom;
		c.make_active = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 19) == 0)
			clock_ms = $urandom;
		else
			clock_ms = clock_ms + $urandom_range(0, 6);
		c.now_ms = clock_ms;
		if (pick < 40) begin
			c.func = FUNC_TICK;
		end else if (pick < 62) begin
			c.func = FUNC_SET_ACTIVE;
			c.make_active = ($urandom_range(0, 4) != 0);
		end else if (pick < 78) begin
			c.func = FUNC_SET_PERIOD;
			if ($urandom_range(0, 9) < 7)
				c.period = $urandom_range(0, 10);
		end else if (pick < 84) begin
			c.func = FUNC_REMOVE;
		end else if (pick < 90) begin
			c.func = FUNC_ADD;
		end else begin
			c.func = FUNC_W'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));
		end
		return c;
	endfunction

	task automatic issue_cmd(input cmd_t c, input bit typed, input result_t typed_res);
		if (!calm && $urandom_range(0, 99) < 12) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 24)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.func <= c.func;
		req_ch.task_index <= c.task_index;
		req_ch.period <= c.period;
		req_ch.make_active <= c.make_active;
		req_ch.now_ms <= c.now_ms;
		do @(posedge clk); while (!req_ch.ready);
		forecast_results(c);
		if (typed) begin
			void'(awaited.pop_back());
			awaited.push_back(typed_res);
		end
	endtask

	task automatic drain_results();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (awaited.size() != 0);
	endtask

	initial begin
		cmd_t c;
		result_t tr;
		int r;
		int k;
		int counted;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.func = FUNC_TICK;
		req_ch.task_index = '0;
		req_ch.period = '0;
		req_ch.make_active = 1'b0;
		req_ch.now_ms = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (r = 0; r < $size(PLAN); r++) begin
			for (k = 0; k < PLAN[r].reps; k++) begin
				c.func = PLAN[r].func;
				c.task_index = PLAN[r].task_index;
				c.period = PLAN[r].period;
				c.make_active = PLAN[r].make_active;
				c.now_ms = PLAN[r].now_ms;
				tr.ok = PLAN[r].ok;
				tr.slot = PLAN[r].slot;
				tr.due = 1'b0;
				tr.last = 1'b1;
				issue_cmd(c, PLAN[r].typed, tr);
			end
		end
		clock_ms = 32'd60;
		drain_results();
		counted = 0;
		while (counted < RANDOM_CMDS) begin
			c = random_cmd();
			if (c.func <= FUNC_SET_PERIOD) begin
				counted++;
				if (counted == 60)
					hold_trigger = 1'b1;
				if (counted == 100)
					drain_results();
			end
			calm = (counted >= 120 && counted < 170);
			issue_cmd(c, 1'b0, '0);
		end
		drain_results();
		repeat (3 * NUM_SLOTS) @(posedge clk);
		if (errors == 0)
			$display("periodic_task_due_scheduler_unit_test: clean");
		else
			$display("periodic_task_due_scheduler_unit_test: errors");
		$finish;
	end

	initial begin
		int hold_left;
		hold_left = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (hold_trigger) begin
				hold_trigger = 1'b0;
				hold_left = HOLD_CYCLES;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 12);
			end
		end
	end

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (awaited.size() == 0) begin
				$display("%0t: unexpected result, actual ok=%0d slot=%0d due=%0d last=%0d",
					$time, rsp_ch.ok, rsp_ch.slot, rsp_ch.due, rsp_ch.last);
				errors++;
			end else begin
				want = awaited.pop_front();
				check_field("ok", want.ok, rsp_ch.ok);
				check_field("slot", want.slot, rsp_ch.slot);
				check_field("due", want.due, rsp_ch.due);
				check_field("last", want.last, rsp_ch.last);
			end
		end
	end

endmodule

// ===== filelist.f =====
src/ptds_pkg.sv
src/ptds_req_if.sv
src/ptds_rsp_if.sv
src/ptds_cell.sv
src/periodic_task_due_scheduler_unit.sv
src/ptds_checker.sv
tb/periodic_task_due_scheduler_unit_test.sv
